[hw/rtl/iapd_pkg.sv]
// ----------------------------------------------------------------------------
// iapd_pkg
// Types, constants and the root table for the interpolated allpass delay.
// ----------------------------------------------------------------------------
package iapd_pkg;

  localparam int Depth    = 4096;
  localparam int Channels = 2;
  localparam int ChW      = 1;
  localparam int PosW     = 12;
  localparam int LenW     = 13;
  localparam int MemAw    = ChW + PosW;
  localparam int MemDepth = Channels * Depth;
  localparam int SampleW  = 24;
  localparam int FracW    = 24;
  localparam int QW       = LenW + FracW;
  localparam int DivDw    = 45;
  localparam int DivSw    = 32;
  localparam int DivCw    = 6;
  localparam int CfgIdxW  = 2;
  localparam int CfgDw    = 24;

  localparam logic [LenW-1:0] MinRing   = 13'd64;
  localparam logic [LenW-1:0] MaxRing   = 13'd4096;
  localparam logic [23:0]     SpmReset  = 24'd2890138;
  localparam logic [23:0]     SpmMin    = 24'd65536;
  localparam logic [31:0]     Log2kQ28  = 32'd2675169849;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DECAY_OFF = 2'd0,
    CFG_MAX_DELAY = 2'd1,
    CFG_SPM       = 2'd2
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DMUL, ST_POS, ST_WRX, ST_RDA, ST_RDB, ST_CAPB,
    ST_INT, ST_ADD, ST_DIVMS, ST_DIVT, ST_EXP, ST_FAC, ST_SHF, ST_FIN, ST_WRY
  } state_e;

  typedef struct packed {
    logic               channel;
    logic signed [23:0] sample_in;
    logic [19:0]        delay_ms;
    logic signed [31:0] coefficient;
  } in_item_t;

  typedef struct packed {
    logic               out_channel;
    logic signed [23:0] sample_out;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DivDw-1:0] dividend;
    logic [DivSw-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivDw-1:0] quotient;
  } div_rsp_t;

  typedef logic [15:0][29:0] ctab_t;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bt;
    logic [63:0] rem;
    r   = '0;
    rem = v;
    bt  = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (bt > rem) bt = bt >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (bt != '0) begin
        if (rem >= r + bt) begin
          rem = rem - (r + bt);
          r   = (r >> 1) + bt;
        end else begin
          r = r >> 1;
        end
        bt = bt >> 2;
      end
    end
    return r;
  endfunction

  // Successive roots of one half in Q0.30: 0.5^(2^-k) for k = 1..16.
  function automatic ctab_t build_ctab();
    ctab_t       tab;
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int k = 0; k < 16; k++) begin
      c      = isqrt64(c << 30);
      tab[k] = c[29:0];
    end
    return tab;
  endfunction

  localparam ctab_t CTab = build_ctab();

endpackage

[hw/rtl/iapd_ram.sv]
// ----------------------------------------------------------------------------
// iapd_ram
// Single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module iapd_ram #(
  parameter int Width = 24,
  parameter int Depth = 8192,
  localparam int Aw   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/iapd_div.sv]
// ----------------------------------------------------------------------------
// iapd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module iapd_div import iapd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DivCw-1:0] cnt_q, cnt_d;
  logic [DivSw-1:0] rem_q, rem_d;
  logic [DivDw-1:0] quo_q, quo_d;
  logic [DivSw-1:0] dsr_q, dsr_d;
  logic [DivSw:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    trial  = {rem_q, quo_q[DivDw-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DivCw'(DivDw);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract when it fits
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = DivSw'(trial - {1'b0, dsr_q});
        quo_d = {quo_q[DivDw-2:0], 1'b1};
      end else begin
        rem_d = trial[DivSw-1:0];
        quo_d = {quo_q[DivDw-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCw'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

[hw/rtl/interpolated_allpass_delay_top.sv]
// ----------------------------------------------------------------------------
// interpolated_allpass_delay_top
// Multichannel allpass with a modulated fractional delay, histories in RAM.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid_i/in_ready_o | in_data_i: channel, sample, delay, coeff
//  out     | out_valid_o/out_ready_i | out_data_o: channel, filtered sample
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One item at a time. Gain mode, zero delay or a zero coefficient skip the
//  divider; decay mode runs the serial divider (one quotient bit a cycle,
//  then the done flag) and the 16-step root product, and a clamped delay
//  adds a second division first.
//  Reset and every write to a defined register clear both history RAMs,
//  all 8192 entries, one entry per cycle; no item is taken meanwhile.
//  A result waits in the output register; a new item is taken while it waits,
//  and that item stalls at its last step until the register frees.
// ----------------------------------------------------------------------------
module interpolated_allpass_delay_top import iapd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDw-1:0]   cfg_data_i
);

  state_e state_q, state_d;

  // configuration and derived ring length
  logic        decay_off_q;
  logic [19:0] max_delay_q;
  logic [23:0] spm_q;
  logic [23:0] rate_q;
  logic [43:0] plen_q;
  logic [LenW-1:0] len_q, len_d;
  logic [20:0] lceil;
  logic [21:0] lraw;
  logic [QW-1:0] lim;
  logic        cfg_hit;

  // clearing sweep and write positions
  logic [MemAw-1:0] clr_q;
  logic [PosW-1:0]  wp_q [Channels];

  // item
  logic               ch_q;
  logic signed [23:0] x_q;
  logic [19:0]        dms_q;
  logic signed [31:0] a_q;
  logic [PosW-1:0]    wh_q;
  logic [43:0]        dfull_q;
  logic               clamped_q;
  logic [PosW-1:0]    ridx_q, ra_q, rb_q;
  logic [FracW-1:0]   fr_q;
  logic               end_q;
  logic signed [23:0] xa_q, ya_q, xb_q, yb_q, dx_q, dy_q;
  logic signed [49:0] pdx_q, pdy_q;
  logic [21:0]        t_q;
  logic               tbig_q;
  logic [26:0]        e_q;
  logic [30:0]        gm_q, gain_q;
  logic [3:0]         k_q;
  logic signed [57:0] prod_q;
  logic               fb16_q;
  out_item_t          out_q;
  logic               out_valid_q;

  // memories
  logic             x_we, y_we;
  logic [MemAw-1:0] mem_addr;
  logic [23:0]      x_wdata, y_wdata, x_rd, y_rd;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_fire, out_free, item_done;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign cfg_hit  = cfg_valid_i && (cfg_index_i == CFG_DECAY_OFF ||
                    cfg_index_i == CFG_MAX_DELAY || cfg_index_i == CFG_SPM);
  assign lim = {len_q, {FracW{1'b0}}};

  // Ring length: ceil(max_delay * rate) + 1, held within 64..4096.
  assign lceil = 21'((plen_q + 44'hFF_FFFF) >> FracW);
  assign lraw  = {1'b0, lceil} + 22'd1;
  always_comb begin
    if (lraw < 22'(MinRing)) begin
      len_d = MinRing;
    end else if (lraw > 22'(MaxRing)) begin
      len_d = MaxRing;
    end else begin
      len_d = lraw[LenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_off_q <= 1'b0;
      max_delay_q <= '0;
      spm_q       <= SpmReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_DECAY_OFF: decay_off_q <= cfg_data_i[0];
        CFG_MAX_DELAY: max_delay_q <= cfg_data_i[19:0];
        CFG_SPM:       spm_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Length pipeline settles long before the clearing pass ends.
  always_ff @(posedge clk_i) begin
    rate_q <= (spm_q < SpmMin) ? SpmMin : spm_q;
    plen_q <= 44'(max_delay_q) * 44'(rate_q);
    len_q  <= len_d;
  end

  // ---------------------------------------------------------------- datapath
  logic [LenW-1:0]    whlen;
  logic [QW-1:0]      dcl, rh0, rh;
  logic               clamp_now, is_end;
  logic [FracW-1:0]   frac;
  logic signed [24:0] dfx, dfy, diffy;
  logic signed [49:0] rx, ry;
  logic [31:0]        mag;
  logic [53:0]        ep;
  logic [60:0]        gp;
  logic [31:0]        rnd;
  logic [10:0]        nexp;
  logic signed [32:0] g33;
  logic signed [57:0] shv;
  logic signed [58:0] ysum;
  logic signed [23:0] ysat;
  logic [PosW:0]      wh_inc;

  assign whlen     = LenW'(wh_q) + len_q;
  assign clamp_now = dfull_q > 44'(lim);
  assign dcl       = clamp_now ? lim : dfull_q[QW-1:0];
  assign rh0       = {whlen, {FracW{1'b0}}} - dcl;
  assign rh        = (rh0 >= lim) ? rh0 - lim : rh0;
  assign is_end    = {1'b0, ridx_q} >= len_q - 1'b1;
  assign frac      = end_q ? '0 : fr_q;
  assign dfx       = 25'(xb_q) - 25'(xa_q);
  assign dfy       = 25'(yb_q) - 25'(ya_q);
  assign rx        = (pdx_q + 50'sd8388608) >>> FracW;
  assign ry        = (pdy_q + 50'sd8388608) >>> FracW;
  assign mag       = a_q[31] ? 32'(-a_q) : 32'(a_q);
  assign ep        = 54'(t_q) * 54'(Log2kQ28);
  assign gp        = 61'(gm_q) * 61'(CTab[k_q]);
  assign nexp      = e_q[26:16];
  assign rnd       = (nexp == '0) ? '0 : (32'd1 << (nexp[4:0] - 5'd1));
  assign diffy     = 25'(dy_q) - 25'(x_q);
  assign wh_inc    = {1'b0, wh_q} + 1'b1;

  always_comb begin
    if (decay_off_q) begin
      g33 = 33'(a_q);
    end else if (a_q[31]) begin
      g33 = -$signed({2'b00, gain_q});
    end else begin
      g33 = $signed({2'b00, gain_q});
    end
  end

  assign shv  = fb16_q ? (prod_q + 58'sd32768) >>> 16
                       : (prod_q + 58'sd536870912) >>> 30;
  assign ysum = (dms_q == '0) ? 59'(x_q) : 59'(dx_q) + 59'(shv);
  always_comb begin
    if (ysum > 59'sd8388607) begin
      ysat = 24'sh7F_FFFF;
    end else if (ysum < -59'sd8388608) begin
      ysat = -24'sh80_0000;
    end else begin
      ysat = ysum[23:0];
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          ch_q  <= in_data_i.channel;
          x_q   <= in_data_i.sample_in;
          dms_q <= in_data_i.delay_ms;
          a_q   <= in_data_i.coefficient;
          wh_q  <= ({1'b0, wp_q[in_data_i.channel]} >= len_q) ? '0
                                                              : wp_q[in_data_i.channel];
        end
      end
      ST_DMUL: dfull_q <= 44'(dms_q) * 44'(rate_q);
      ST_POS: begin
        clamped_q <= clamp_now;
        ridx_q    <= rh[QW-2:FracW];
        fr_q      <= rh[FracW-1:0];
      end
      ST_WRX: begin
        end_q <= is_end;
        ra_q  <= is_end ? PosW'(len_q - 1'b1) : ridx_q;
        rb_q  <= is_end ? PosW'(len_q - 1'b1) : ridx_q + 1'b1;
      end
      ST_RDB: begin
        xa_q <= x_rd;
        ya_q <= y_rd;
      end
      ST_CAPB: begin
        xb_q <= x_rd;
        yb_q <= y_rd;
      end
      ST_INT: begin
        pdx_q <= dfx * $signed({1'b0, frac});
        pdy_q <= dfy * $signed({1'b0, frac});
      end
      ST_ADD: begin
        dx_q   <= xa_q + rx[23:0];
        dy_q   <= ya_q + ry[23:0];
        gain_q <= '0;
      end
      ST_DIVT: begin
        t_q    <= div_rsp.quotient[21:0];
        tbig_q <= |div_rsp.quotient[DivDw-1:22];
      end
      ST_EXP: begin
        e_q  <= 27'((ep + 54'd134217728) >> 28);
        gm_q <= 31'd1 << 30;
        k_q  <= '0;
      end
      ST_FAC: begin
        if (e_q[4'd15 - k_q]) begin
          gm_q <= 31'((gp + 61'd536870912) >> 30);
        end
        k_q <= k_q + 1'b1;
      end
      ST_SHF: begin
        if (tbig_q || nexp >= 11'd31) begin
          gain_q <= '0;
        end else begin
          gain_q <= 31'(({1'b0, gm_q} + rnd) >> nexp[4:0]);
        end
      end
      ST_FIN: begin
        prod_q <= g33 * 58'(diffy);
        fb16_q <= decay_off_q;
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------- control regs
  assign item_done = (state_q == ST_WRY) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < Channels; c++) wp_q[c] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_hit) begin
        clr_q <= '0;
        for (int c = 0; c < Channels; c++) wp_q[c] <= '0;
      end else if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end else if (item_done) begin
        wp_q[ch_q] <= (wh_inc == (PosW+1)'(len_q)) ? '0 : wh_inc[PosW-1:0];
      end
      if (item_done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_done) begin
      out_q.out_channel <= ch_q;
      out_q.sample_out  <= ysat;
    end
  end

  // -------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == '1) state_d = ST_IDLE;
      ST_IDLE:  if (in_fire) state_d = ST_DMUL;
      ST_DMUL:  state_d = ST_POS;
      ST_POS:   state_d = ST_WRX;
      ST_WRX:   state_d = ST_RDA;
      ST_RDA:   state_d = ST_RDB;
      ST_RDB:   state_d = ST_CAPB;
      ST_CAPB:  state_d = ST_INT;
      ST_INT:   state_d = ST_ADD;
      ST_ADD: begin
        if (dms_q == '0 || decay_off_q || a_q == '0) begin
          state_d = ST_FIN;
        end else if (clamped_q) begin
          state_d = ST_DIVMS;
        end else begin
          state_d = ST_DIVT;
        end
      end
      ST_DIVMS: if (div_rsp.done) state_d = ST_DIVT;
      ST_DIVT:  if (div_rsp.done) state_d = ST_EXP;
      ST_EXP:   state_d = ST_FAC;
      ST_FAC:   if (k_q == 4'd15) state_d = ST_SHF;
      ST_SHF:   state_d = ST_FIN;
      ST_FIN:   state_d = ST_WRY;
      ST_WRY:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
    // any write to a defined register restarts the clearing pass
    if (cfg_hit) state_d = ST_CLEAR;
  end

  // ----------------------------------------------------------------- outputs
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    x_we       = 1'b0;
    y_we       = 1'b0;
    x_wdata    = '0;
    y_wdata    = '0;
    mem_addr   = {ch_q, wh_q};
    div_req    = '0;
    unique case (state_q)
      ST_CLEAR: begin
        x_we     = 1'b1;
        y_we     = 1'b1;
        mem_addr = clr_q;
      end
      ST_WRX: begin
        x_we    = 1'b1;
        x_wdata = x_q;
      end
      ST_RDA: mem_addr = {ch_q, ra_q};
      ST_RDB: mem_addr = {ch_q, rb_q};
      ST_ADD: begin
        // clamped delay: first find the clamped delay in ms; else delay over coefficient
        div_req.start    = (dms_q != '0) && !decay_off_q && (a_q != '0);
        div_req.dividend = clamped_q ? DivDw'(lim) : {1'b0, dms_q, {FracW{1'b0}}};
        div_req.divisor  = clamped_q ? DivSw'(rate_q) : mag;
      end
      ST_DIVMS: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = {div_rsp.quotient[20:0], {FracW{1'b0}}};
        div_req.divisor  = mag;
      end
      ST_WRY: begin
        y_we    = out_free;
        y_wdata = ysat;
      end
      default: ;
    endcase
  end

  iapd_ram #(.Width(SampleW), .Depth(MemDepth)) u_xram (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .addr_i  (mem_addr),
    .wdata_i (x_wdata),
    .rdata_o (x_rd)
  );

  iapd_ram #(.Width(SampleW), .Depth(MemDepth)) u_yram (
    .clk_i   (clk_i),
    .we_i    (y_we),
    .addr_i  (mem_addr),
    .wdata_i (y_wdata),
    .rdata_o (y_rd)
  );

  iapd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hw/rtl/iapd_check.sv]
// ----------------------------------------------------------------------------
// iapd_check
// Port-level checks for the interpolated allpass delay.
// ----------------------------------------------------------------------------
module iapd_check import iapd_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input out_item_t          out_data_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [CfgIdxW-1:0] cfg_index_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result dropped or changed");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in work");

  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o && (cfg_index_i == CFG_DECAY_OFF ||
    cfg_index_i == CFG_MAX_DELAY || cfg_index_i == CFG_SPM) |=> !in_ready_o)
    else $error("item taken during history clear");

endmodule

bind interpolated_allpass_delay_top iapd_check u_check (.*);

[test/allpass_delay_checker.sv]
// ----------------------------------------------------------------------------
// allpass_delay_checker
// Watches the item, result and register channels, predicts every filtered
// sample and compares it with what the block returns.
// ----------------------------------------------------------------------------
module allpass_delay_checker import iapd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  in_item_t           in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  out_item_t          out_data_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDw-1:0]   cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam logic [63:0] Log2ThousandQ28 = 64'd2675169849;
  localparam logic [63:0] OneQ24          = 64'd1 << 24;

  logic               gain_mode;
  logic [19:0]        max_ms;
  logic [23:0]        spm;
  logic signed [23:0] x_hist [Channels][Depth];
  logic signed [23:0] y_hist [Channels][Depth];
  logic [63:0]        wr_pos [Channels];
  out_item_t          expected_out [$];
  int                 fails;

  function automatic void clear_history();
    for (int c = 0; c < Channels; c++) begin
      wr_pos[c] = '0;
      for (int i = 0; i < Depth; i++) begin
        x_hist[c][i] = '0;
        y_hist[c][i] = '0;
      end
    end
  endfunction

  function automatic logic [63:0] eff_rate();
    return (spm < 24'd65536) ? 64'd65536 : 64'(spm);
  endfunction

  function automatic logic [63:0] ring_len();
    logic [63:0] p;
    logic [63:0] l;
    p = 64'(max_ms) * eff_rate();
    l = ((p + OneQ24 - 1) >> 24) + 1;
    if (l < 64) l = 64;
    if (l > Depth) l = Depth;
    return l;
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // |gain| = 0.001^(ms/mag) in Q2.30; ms in Q.8, mag in Q.16, mag nonzero
  function automatic logic [63:0] decay_mag(logic [63:0] ms_q8, logic [63:0] mag);
    logic [63:0] t;
    logic [63:0] e;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] g;
    logic [63:0] c;
    t = (ms_q8 << 24) / mag;
    if (t >= (64'd1 << 22)) return '0;
    e = (t * Log2ThousandQ28 + (64'd1 << 27)) >> 28;
    n = e >> 16;
    f = e & 64'hFFFF;
    if (n >= 31) return '0;
    g = 64'd1 << 30;
    c = 64'd1 << 29;
    for (int i = 1; i <= 16; i++) begin
      c = floor_root(c << 30);
      if (f[16-i]) g = (g * c + (64'd1 << 29)) >> 30;
    end
    if (n > 0) g = (g + (64'd1 << (n - 1))) >> n;
    return g;
  endfunction

  function automatic longint read_interp(logic ch, logic out_side, logic [63:0] len,
                                         logic [63:0] pos);
    logic [63:0] idx;
    longint      fr;
    longint      ya;
    longint      yb;
    idx = pos >> 24;
    fr  = longint'(pos & (OneQ24 - 1));
    if (idx >= len - 1) return out_side ? y_hist[ch][len-1] : x_hist[ch][len-1];
    ya = out_side ? y_hist[ch][idx] : x_hist[ch][idx];
    yb = out_side ? y_hist[ch][idx+1] : x_hist[ch][idx+1];
    return ya + (((yb - ya) * fr + (longint'(1) << 23)) >>> 24);
  endfunction

  // Filter one sample and advance that channel's history.
  function automatic out_item_t filter_sample(in_item_t it);
    logic        ch;
    longint      x;
    longint      a;
    longint      dx;
    longint      dy;
    longint      y;
    longint      g;
    logic [63:0] dms;
    logic [63:0] len;
    logic [63:0] rate;
    logic [63:0] lim;
    logic [63:0] d;
    logic [63:0] rh;
    logic [63:0] wh;
    logic [63:0] mag;
    logic [63:0] ms;
    logic        clamped;
    int          fb;
    out_item_t   res;
    ch   = it.channel;
    x    = it.sample_in;
    a    = it.coefficient;
    dms  = 64'(it.delay_ms);
    len  = ring_len();
    rate = eff_rate();
    lim  = len << 24;
    wh   = wr_pos[ch];
    if (wh >= len) wh = '0;
    x_hist[ch][wh] = x[23:0];
    d = dms * rate;
    clamped = d > lim;
    if (clamped) d = lim;
    rh = ((wh + len) << 24) - d;
    if (rh >= lim) rh = rh - lim;
    dx = read_interp(ch, 1'b0, len, rh);
    dy = read_interp(ch, 1'b1, len, rh);
    if (dms == 0) begin
      y = x;
    end else begin
      if (gain_mode) begin
        g  = a;
        fb = 16;
      end else if (a == 0) begin
        g  = 0;
        fb = 30;
      end else begin
        mag = (a < 0) ? 64'(-a) : 64'(a);
        ms  = clamped ? lim / rate : dms;
        g   = longint'(decay_mag(ms, mag));
        if (a < 0) g = -g;
        fb  = 30;
      end
      y = dx + ((g * (dy - x) + (longint'(1) << (fb - 1))) >>> fb);
    end
    if (y > 8388607) y = 8388607;
    if (y < -8388608) y = -8388608;
    y_hist[ch][wh] = y[23:0];
    wr_pos[ch] = (wh + 1) % len;
    res.out_channel = it.channel;
    res.sample_out  = y[23:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_item;
    if (!rst_ni) begin
      gain_mode = 1'b0;
      max_ms    = '0;
      spm       = SpmReset;
      clear_history();
      expected_out.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        // a register write flushes both histories; unused index does nothing
        case (cfg_index_i)
          CFG_DECAY_OFF: begin
            gain_mode = cfg_data_i[0];
            clear_history();
          end
          CFG_MAX_DELAY: begin
            max_ms = cfg_data_i[19:0];
            clear_history();
          end
          CFG_SPM: begin
            spm = cfg_data_i;
            clear_history();
          end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_out.push_back(filter_sample(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_out.size() == 0) begin
          fails++;
          $display("%0t: unexpected result ch=%0d sample=%0d", $time,
                   out_data_i.out_channel, out_data_i.sample_out);
        end else begin
          exp_item = expected_out.pop_front();
          if (out_data_i.out_channel !== exp_item.out_channel) begin
            fails++;
            $display("%0t: out_channel expected %0d got %0d", $time,
                     exp_item.out_channel, out_data_i.out_channel);
          end
          if (out_data_i.sample_out !== exp_item.sample_out) begin
            fails++;
            $display("%0t: sample_out expected %0d got %0d", $time,
                     exp_item.sample_out, out_data_i.sample_out);
          end
        end
      end
      fail_count_o <= fails;
      pending_o    <= expected_out.size();
    end
  end

endmodule

[test/tb_interpolated_allpass_delay_top.sv]
// ----------------------------------------------------------------------------
// tb_interpolated_allpass_delay_top
// Drives directed and random samples through several register settings,
// with random gaps on both sides outside one no-gap stretch; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_interpolated_allpass_delay_top;
  import iapd_pkg::*;

  // Index past the last register: the write is taken but changes nothing.
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDw-1:0]   cfg_data;
  int                 fail_count;
  int                 pending;

  // Stimulus shaping: current mode and delay ceiling, and the no-gap stretch.
  logic               gain_mode;
  int unsigned        max_ms_cur;
  logic               quiet;
  logic               holding;

  interpolated_allpass_delay_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  allpass_delay_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Hold off results about one cycle in five, except in the no-gap stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 21);
    end
  end

  // Present one sample and wait for its transfer; valid stays high unless
  // a gap follows, so back-to-back items never toggle it within a step.
  task automatic push_item(in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    holding  = 1'b1;
    do @(negedge clk_i); while (!in_ready);
    @(posedge clk_i);
    if (!quiet && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      holding  = 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain();
    if (holding) begin
      in_valid <= 1'b0;
      holding  = 1'b0;
    end
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // Write one register; keep valid up when another write follows.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDw-1:0] data,
                           logic last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk_i); while (!cfg_ready);
    @(posedge clk_i);
    if (last) cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t mk_item(logic ch, int s, int d, int c);
    in_item_t it;
    it.channel     = ch;
    it.sample_in   = s[23:0];
    it.delay_ms    = d[19:0];
    it.coefficient = c;
    return it;
  endfunction

  // Random sample: delays mostly within the ring, coefficients mostly in
  // the useful range for the current mode, the rest zero or full-range noise.
  function automatic in_item_t rand_item();
    in_item_t    it;
    int unsigned pick;
    int unsigned span;
    int unsigned mag;
    it.channel = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 8) it.sample_in = pick[0] ? 24'h7FFFFF : 24'h800000;
    else it.sample_in = 24'($urandom);
    pick = $urandom_range(99);
    if (pick < 5) it.delay_ms = '0;
    else if (pick < 20) it.delay_ms = 20'($urandom);
    else it.delay_ms = 20'($urandom_range(max_ms_cur + 16, 1));
    pick = $urandom_range(99);
    if (pick < 10) begin
      it.coefficient = '0;
    end else if (pick < 30) begin
      it.coefficient = $urandom;
    end else if (gain_mode) begin
      it.coefficient = int'($urandom_range(131072)) - 65536;
    end else begin
      span = 32'(it.delay_ms) << 8;
      if (pick < 40) mag = $urandom_range(255, 1);
      else mag = $urandom_range(span * 2 + 1, span / 32 + 1);
      it.coefficient = $urandom_range(1) ? -int'(mag) : int'(mag);
    end
    return it;
  endfunction

  task automatic run_random(int n, logic pause_midway);
    for (int i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) drain();
      push_item(rand_item());
    end
    drain();
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_DECAY_OFF;
    cfg_data   = '0;
    quiet      = 1'b0;
    holding    = 1'b0;
    gain_mode  = 1'b0;
    max_ms_cur = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: decay mode, shortest ring. Extremes of every field,
    // zero delay pass-through, clamped delay, zero coefficient, decay too long.
    push_item(mk_item(1'b0, 8388607, 0, 0));
    push_item(mk_item(1'b1, -8388608, 0, 65536));
    push_item(mk_item(1'b0, 8388607, 256, 65536));
    push_item(mk_item(1'b1, -8388608, 1048575, 32'h7FFFFFFF));
    push_item(mk_item(1'b0, 1234567, 1048575, 32'h80000000));
    push_item(mk_item(1'b0, -1, 1, 0));
    push_item(mk_item(1'b1, 100000, 128, 1));
    push_item(mk_item(1'b0, 5000000, 200, -6553600));
    push_item(mk_item(1'b1, 0, 371, 655360));
    push_item(mk_item(1'b0, 8388607, 64, 3000000));
    push_item(mk_item(1'b0, -4000000, 37, -65536));
    push_item(mk_item(1'b1, 2222222, 5, 131072));
    push_item(mk_item(1'b0, -8388608, 370, 32'h7FFFFFFF));
    push_item(mk_item(1'b1, 7777777, 1048575, -1));
    push_item(mk_item(1'b0, 3, 17, 20000));
    push_item(mk_item(1'b1, -3, 99, -20000));
    drain();

    // Gain mode, 20 ms at 48 kHz; pause halfway until every result is back.
    write_reg(CFG_DECAY_OFF, {23'($urandom_range(8388607)), 1'b1}, 1'b0);
    write_reg(CFG_MAX_DELAY, 24'd5120, 1'b0);
    write_reg(CFG_SPM, 24'd3145728, 1'b1);
    gain_mode = 1'b1;
    max_ms_cur = 5120;
    run_random(300, 1'b1);

    // Decay mode, largest delay at the lowest rate: ring clamps to full depth.
    write_reg(CFG_DECAY_OFF, {23'($urandom_range(8388607)), 1'b0}, 1'b0);
    write_reg(CFG_MAX_DELAY, 24'hFFFFF, 1'b0);
    write_reg(CFG_SPM, 24'd65536, 1'b1);
    gain_mode = 1'b0;
    max_ms_cur = 4096 * 256;
    run_random(300, 1'b0);

    // 192 kHz rate with zero max delay (shortest ring); no gaps on either side.
    write_reg(CFG_SPM, 24'd12582912, 1'b0);
    write_reg(CFG_MAX_DELAY, 24'd0, 1'b0);
    write_reg(CfgUnused, 24'($urandom), 1'b1);
    quiet = 1'b1;
    max_ms_cur = 0;
    run_random(295, 1'b0);
    quiet = 1'b0;

    // Rate below the floor, random max delay, gain mode.
    max_ms_cur = $urandom_range(8000, 300);
    write_reg(CFG_SPM, 24'd0, 1'b0);
    write_reg(CFG_MAX_DELAY, {4'($urandom_range(15)), 20'(max_ms_cur)}, 1'b0);
    write_reg(CFG_DECAY_OFF, {23'($urandom_range(8388607)), 1'b1}, 1'b1);
    gain_mode = 1'b1;
    run_random(295, 1'b0);

    // All-ones rate, random max delay, decay mode.
    max_ms_cur = $urandom_range(20000, 1);
    write_reg(CFG_SPM, 24'hFFFFFF, 1'b0);
    write_reg(CFG_MAX_DELAY, 24'(max_ms_cur), 1'b0);
    write_reg(CFG_DECAY_OFF, {23'($urandom_range(8388607)), 1'b0}, 1'b1);
    gain_mode = 1'b0;
    run_random(295, 1'b0);

    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_interpolated_allpass_delay_top: PASS");
    end else begin
      $display("tb_interpolated_allpass_delay_top: FAIL");
    end
    $finish;
  end

  // Bound the run well past the slowest correct one.
  initial begin
    #4000000;
    $display("tb_interpolated_allpass_delay_top: FAIL");
    $finish;
  end

endmodule
